/* rtl/srsr_pkg.sv */
// Shared types, constants and the square-root step for the row span rasterizer.
package srsr_pkg;

    localparam int MAX_CANVAS_DIM = 4096;
    localparam int CoordW = 12;
    localparam int DimW   = 13;
    localparam int EndW   = 14;

    // Canvas size limit: the smaller of the configured maximum and the span field range.
    localparam logic [DimW-1:0] DIM_LIMIT =
        (MAX_CANVAS_DIM > 4096) ? 13'd4096 : DimW'(MAX_CANVAS_DIM);
    localparam logic [DimW-1:0] DIM_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_RECT_FILL,
        OP_RECT_LINE,
        OP_CIRC_FILL,
        OP_CIRC_LINE
    } op_t;

    typedef enum logic {
        CFG_WIDTH,
        CFG_HEIGHT
    } cfg_idx_t;

    // How the final stage builds the spans of one request.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PRESET,
        KIND_CIRCLE
    } kind_t;

    typedef logic signed [EndW-1:0] end_t;

    // Up to two unclipped spans.
    typedef struct packed {
        logic en0;
        end_t lo0;
        end_t hi0;
        logic en1;
        end_t lo1;
        end_t hi1;
    } pair_t;

    // Request context carried down the pipeline.
    typedef struct packed {
        kind_t             kind;
        logic              split;
        logic [CoordW-1:0] ax;
        logic [DimW-1:0]   w;
        pair_t             preset;
    } ctx_t;

    // Partial square root: remainder and root bits found so far.
    typedef struct packed {
        logic [23:0]       rem;
        logic [CoordW-1:0] root;
    } root_t;

    // One digit of a restoring square root, deciding root bit k.
    function automatic root_t sqrt_step(root_t s, int k);
        logic [23:0] t;
        root_t o;
        t = (24'(s.root) << (k + 1)) | (24'd1 << (2 * k));
        o = s;
        if (s.rem >= t)
        begin
            o.rem  = s.rem - t;
            o.root = s.root | (12'd1 << k);
        end
        return o;
    endfunction

endpackage

/* rtl/srsr_front.sv */
// Front stages: request decode, rectangle and degenerate spans, squares and differences.
module srsr_front
    import srsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              take,
    input  logic [1:0]        operation,
    input  logic [CoordW-1:0] first_x,
    input  logic [CoordW-1:0] first_y,
    input  logic [CoordW-1:0] second_x,
    input  logic [CoordW-1:0] second_y,
    input  logic [CoordW-1:0] stroke,
    input  logic [CoordW-1:0] row,
    input  logic [DimW-1:0]   canvas_width,
    input  logic [DimW-1:0]   canvas_height,
    output logic              front_valid,
    output ctx_t              front_ctx,
    output root_t             front_a,
    output root_t             front_b
);

    typedef struct packed {
        op_t               op;
        logic [CoordW-1:0] ax;
        logic [CoordW-1:0] ay;
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] sw;
        logic [CoordW-1:0] x0;
        logic [CoordW-1:0] x1;
        logic [CoordW-1:0] y0;
        logic [CoordW-1:0] y1;
        logic [CoordW-1:0] r;
        logic [CoordW-1:0] dy;
        logic [DimW-1:0]   w;
        logic              rowok;
    } dec_t;

    typedef struct packed {
        ctx_t        ctx;
        logic        line;
        logic [23:0] r2;
        logic [23:0] dy2;
        logic [23:0] in2;
    } sq_t;

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    dec_t  s1_reg, s1_next;
    sq_t   s2_reg, s2_next;
    ctx_t  s3_ctx_reg, s3_ctx_next;
    logic [23:0] s3_ma_reg, s3_ma_next, s3_mb_reg, s3_mb_next;

    logic [CoordW-1:0] rx, ry;
    logic [DimW-1:0]   h_lim;

    logic [DimW-1:0] rw, rh;
    logic            fill, inrow, solid, merge;
    end_t            le, rs, so, eo, ay_e, row_e, ax_e, sw_e;
    end_t            inner_s;
    logic [CoordW-1:0] inner;
    pair_t           pre;

    // Stage one: ordering, distances, stroke and canvas limits.
    always_comb
    begin
        s1_next.op  = op_t'(operation);
        s1_next.ax  = first_x;
        s1_next.ay  = first_y;
        s1_next.row = row;
        s1_next.sw  = (stroke == '0) ? 12'd1 : stroke;
        s1_next.x0  = (first_x < second_x) ? first_x : second_x;
        s1_next.x1  = (first_x < second_x) ? second_x : first_x;
        s1_next.y0  = (first_y < second_y) ? first_y : second_y;
        s1_next.y1  = (first_y < second_y) ? second_y : first_y;
        rx = (first_x >= second_x) ? first_x - second_x : second_x - first_x;
        ry = (first_y >= second_y) ? first_y - second_y : second_y - first_y;
        s1_next.r   = (rx > ry) ? rx : ry;
        s1_next.dy  = (row >= first_y) ? row - first_y : first_y - row;
        s1_next.w   = (canvas_width > DIM_LIMIT) ? DIM_LIMIT : canvas_width;
        h_lim       = (canvas_height > DIM_LIMIT) ? DIM_LIMIT : canvas_height;
        s1_next.rowok = ({1'b0, row} < h_lim) && (s1_next.w != '0);
    end

    // Stage two: rectangle and zero-radius spans, and the three squares.
    always_comb
    begin
        ax_e  = end_t'({2'b00, s1_reg.ax});
        ay_e  = end_t'({2'b00, s1_reg.ay});
        row_e = end_t'({2'b00, s1_reg.row});
        sw_e  = end_t'({2'b00, s1_reg.sw});

        rw = {1'b0, s1_reg.x1} - {1'b0, s1_reg.x0} + 13'd1;
        rh = {1'b0, s1_reg.y1} - {1'b0, s1_reg.y0} + 13'd1;
        fill = (s1_reg.op == OP_RECT_FILL) || ({1'b0, s1_reg.sw} >= rw)
            || ({1'b0, s1_reg.sw} >= rh);
        inrow = (s1_reg.row >= s1_reg.y0) && (s1_reg.row <= s1_reg.y1);
        solid = fill || ((s1_reg.row - s1_reg.y0) < s1_reg.sw)
            || ((s1_reg.y1 - s1_reg.row) < s1_reg.sw);
        le = end_t'({2'b00, s1_reg.x0}) + sw_e - 14'sd1;
        rs = end_t'({2'b00, s1_reg.x1}) - sw_e + 14'sd1;
        merge = rs <= le + 14'sd1;

        // A zero-radius outline is a square stamp of side stroke.
        so = -end_t'({3'b000, s1_reg.sw[CoordW-1:1]});
        eo = so + sw_e - 14'sd1;

        pre = '0;
        s2_next.ctx.kind = KIND_NONE;
        if (s1_reg.rowok)
        begin
            if (s1_reg.op == OP_RECT_FILL || s1_reg.op == OP_RECT_LINE)
            begin
                s2_next.ctx.kind = KIND_PRESET;
                if (inrow)
                begin
                    pre.en0 = 1'b1;
                    pre.lo0 = end_t'({2'b00, s1_reg.x0});
                    pre.hi0 = end_t'({2'b00, s1_reg.x1});
                    if (!solid && !merge)
                    begin
                        pre.hi0 = le;
                        pre.en1 = 1'b1;
                        pre.lo1 = rs;
                        pre.hi1 = end_t'({2'b00, s1_reg.x1});
                    end
                end
            end
            else if (s1_reg.r == '0)
            begin
                s2_next.ctx.kind = KIND_PRESET;
                if (s1_reg.op == OP_CIRC_FILL)
                begin
                    if (s1_reg.row == s1_reg.ay)
                    begin
                        pre.en0 = 1'b1;
                        pre.lo0 = ax_e;
                        pre.hi0 = ax_e;
                    end
                end
                else if (row_e >= ay_e + so && row_e <= ay_e + eo)
                begin
                    pre.en0 = 1'b1;
                    pre.lo0 = ax_e + so;
                    pre.hi0 = ax_e + eo;
                end
            end
            else if (s1_reg.dy <= s1_reg.r)
            begin
                s2_next.ctx.kind = KIND_CIRCLE;
            end
        end

        inner_s = end_t'({2'b00, s1_reg.r}) - sw_e + 14'sd1;
        inner   = (inner_s < 0) ? '0 : inner_s[CoordW-1:0];

        s2_next.ctx.split  = 1'b0;
        s2_next.ctx.ax     = s1_reg.ax;
        s2_next.ctx.w      = s1_reg.w;
        s2_next.ctx.preset = pre;
        s2_next.line = (s1_reg.op == OP_CIRC_LINE);
        s2_next.r2   = {12'd0, s1_reg.r} * {12'd0, s1_reg.r};
        s2_next.dy2  = {12'd0, s1_reg.dy} * {12'd0, s1_reg.dy};
        s2_next.in2  = {12'd0, inner} * {12'd0, inner};
    end

    // Stage three: radicands of the outer and inner half widths.
    always_comb
    begin
        s3_ctx_next       = s2_reg.ctx;
        s3_ctx_next.split = s2_reg.line && (s2_reg.in2 > s2_reg.dy2);
        s3_ma_next        = s2_reg.r2 - s2_reg.dy2;
        s3_mb_next        = s2_reg.in2 - s2_reg.dy2;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_ctx_reg <= s3_ctx_next;
            s3_ma_reg  <= s3_ma_next;
            s3_mb_reg  <= s3_mb_next;
        end
    end

    assign front_valid = s3_valid_reg;
    assign front_ctx   = s3_ctx_reg;
    assign front_a     = '{rem: s3_ma_reg, root: '0};
    assign front_b     = '{rem: s3_mb_reg, root: '0};

endmodule

/* rtl/srsr_root.sv */
// Four-stage pipelined square root, three root bits per stage, for both radicands.
module srsr_root
    import srsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  ctx_t  in_ctx,
    input  root_t in_a,
    input  root_t in_b,
    output logic  out_valid,
    output ctx_t  out_ctx,
    output root_t out_a,
    output root_t out_b
);

    localparam int Stages = 4;
    localparam int StepsPerStage = 3;

    logic  vld_reg [Stages];
    ctx_t  ctx_reg [Stages];
    root_t a_reg   [Stages];
    root_t b_reg   [Stages];

    for (genvar j = 0; j < Stages; j++)
    begin : g_stage
        logic  vld_prev;
        ctx_t  ctx_prev;
        root_t a_prev, b_prev, a_next, b_next;

        if (j == 0)
        begin : g_first
            assign vld_prev = in_valid;
            assign ctx_prev = in_ctx;
            assign a_prev   = in_a;
            assign b_prev   = in_b;
        end
        else
        begin : g_rest
            assign vld_prev = vld_reg[j-1];
            assign ctx_prev = ctx_reg[j-1];
            assign a_prev   = a_reg[j-1];
            assign b_prev   = b_reg[j-1];
        end

        // Three root digits, highest first.
        always_comb
        begin
            a_next = a_prev;
            b_next = b_prev;
            for (int i = 0; i < StepsPerStage; i++)
            begin
                a_next = sqrt_step(a_next, CoordW - 1 - StepsPerStage * j - i);
                b_next = sqrt_step(b_next, CoordW - 1 - StepsPerStage * j - i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[j] <= ctx_prev;
                a_reg[j]   <= a_next;
                b_reg[j]   <= b_next;
            end
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign out_ctx   = ctx_reg[Stages-1];
    assign out_a     = a_reg[Stages-1];
    assign out_b     = b_reg[Stages-1];

endmodule

/* rtl/srsr_emit.sv */
// Final stage: circle spans, clipping, packing and the one-result-per-cycle output.
module srsr_emit
    import srsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ctx_t              in_ctx,
    input  root_t             in_a,
    input  root_t             in_b,
    output logic              adv,
    output logic              strobe,
    output logic              span_valid,
    output logic [CoordW-1:0] span_start,
    output logic [CoordW-1:0] span_end,
    output logic              last
);

    pair_t             cand;
    end_t              ax_e, a_e, b_e, wm1, lo0_c, hi0_c, lo1_c, hi1_c;
    logic [CoordW:0]   b_ceil;
    logic              keep0, keep1;

    logic              s8_valid_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic [CoordW-1:0] lo0_reg, lo0_next, hi0_reg, hi0_next;
    logic [CoordW-1:0] lo1_reg, lo1_next, hi1_reg, hi1_next;

    logic              phase_reg, phase_next;
    logic              strobe_reg, strobe_next;
    logic              span_valid_reg, span_valid_next;
    logic [CoordW-1:0] span_start_reg, span_start_next;
    logic [CoordW-1:0] span_end_reg, span_end_next;
    logic              last_reg, last_next;

    // Candidate spans, then clipping to the canvas and packing left to right.
    always_comb
    begin
        ax_e   = end_t'({2'b00, in_ctx.ax});
        a_e    = end_t'({2'b00, in_a.root});
        b_ceil = {1'b0, in_b.root} + {{CoordW{1'b0}}, (in_b.rem != '0)};
        b_e    = end_t'({1'b0, b_ceil});

        cand = '0;
        case (in_ctx.kind)
            KIND_PRESET:
            begin
                cand = in_ctx.preset;
            end
            KIND_CIRCLE:
            begin
                if (!in_ctx.split)
                begin
                    cand.en0 = 1'b1;
                    cand.lo0 = ax_e - a_e;
                    cand.hi0 = ax_e + a_e;
                end
                else if (b_e <= a_e)
                begin
                    cand.en0 = 1'b1;
                    cand.lo0 = ax_e - a_e;
                    cand.hi0 = ax_e - b_e;
                    cand.en1 = 1'b1;
                    cand.lo1 = ax_e + b_e;
                    cand.hi1 = ax_e + a_e;
                end
            end
            default:
            begin
                cand = '0;
            end
        endcase

        wm1   = end_t'({1'b0, in_ctx.w}) - 14'sd1;
        lo0_c = (cand.lo0 < 0) ? '0 : cand.lo0;
        hi0_c = (cand.hi0 > wm1) ? wm1 : cand.hi0;
        lo1_c = (cand.lo1 < 0) ? '0 : cand.lo1;
        hi1_c = (cand.hi1 > wm1) ? wm1 : cand.hi1;
        keep0 = cand.en0 && (lo0_c <= hi0_c);
        keep1 = cand.en1 && (lo1_c <= hi1_c);

        cnt_next = {1'b0, keep0} + {1'b0, keep1};
        lo0_next = keep0 ? lo0_c[CoordW-1:0] : lo1_c[CoordW-1:0];
        hi0_next = keep0 ? hi0_c[CoordW-1:0] : hi1_c[CoordW-1:0];
        lo1_next = lo1_c[CoordW-1:0];
        hi1_next = hi1_c[CoordW-1:0];
    end

    // The pipeline holds while the first of two spans goes out.
    assign adv = !(s8_valid_reg && (cnt_reg == 2'd2) && !phase_reg);

    // Result selection: one transfer per cycle.
    always_comb
    begin
        phase_next      = 1'b0;
        strobe_next     = 1'b0;
        span_valid_next = 1'b0;
        span_start_next = '0;
        span_end_next   = '0;
        last_next       = 1'b1;
        if (s8_valid_reg)
        begin
            strobe_next = 1'b1;
            if (phase_reg)
            begin
                span_valid_next = 1'b1;
                span_start_next = lo1_reg;
                span_end_next   = hi1_reg;
            end
            else if (cnt_reg != 2'd0)
            begin
                span_valid_next = 1'b1;
                span_start_next = lo0_reg;
                span_end_next   = hi0_reg;
                if (cnt_reg == 2'd2)
                begin
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s8_valid_reg <= in_valid;
            end
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cnt_reg <= cnt_next;
            lo0_reg <= lo0_next;
            hi0_reg <= hi0_next;
            lo1_reg <= lo1_next;
            hi1_reg <= hi1_next;
        end
        span_valid_reg <= span_valid_next;
        span_start_reg <= span_start_next;
        span_end_reg   <= span_end_next;
        last_reg       <= last_next;
    end

    assign strobe     = strobe_reg;
    assign span_valid = span_valid_reg;
    assign span_start = span_start_reg;
    assign span_end   = span_end_reg;
    assign last       = last_reg;

endmodule

/* rtl/shape_row_span_rasterizer_core.sv */
// Path of a request: front stages, square-root stages, final stage, then the output registers.
// Throughput: one request per cycle while busy is low; a request with two spans sends them
// in turn on the single result channel, and busy is high for one cycle before its first span.
// The receiver cannot stall; each result is shown for one cycle with strobe.
// Reset clears the stage valid bits and strobe and sets both canvas dimensions to 4096.
module shape_row_span_rasterizer_core
    import srsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DimW-1:0]   cfg_data,
    input  logic [1:0]        operation,
    input  logic [CoordW-1:0] first_x,
    input  logic [CoordW-1:0] first_y,
    input  logic [CoordW-1:0] second_x,
    input  logic [CoordW-1:0] second_y,
    input  logic [CoordW-1:0] stroke,
    input  logic [CoordW-1:0] row,
    output logic              strobe,
    output logic              span_valid,
    output logic [CoordW-1:0] span_start,
    output logic [CoordW-1:0] span_end,
    output logic              last
);

    logic [DimW-1:0] width_reg, height_reg;
    logic            adv;
    logic            front_valid, root_valid;
    ctx_t            front_ctx, root_ctx;
    root_t           front_a, front_b, root_a, root_b;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign busy = !adv;

    srsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .take          (start),
        .operation     (operation),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .stroke        (stroke),
        .row           (row),
        .canvas_width  (width_reg),
        .canvas_height (height_reg),
        .front_valid   (front_valid),
        .front_ctx     (front_ctx),
        .front_a       (front_a),
        .front_b       (front_b)
    );

    srsr_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_ctx    (front_ctx),
        .in_a      (front_a),
        .in_b      (front_b),
        .out_valid (root_valid),
        .out_ctx   (root_ctx),
        .out_a     (root_a),
        .out_b     (root_b)
    );

    srsr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (root_valid),
        .in_ctx     (root_ctx),
        .in_a       (root_a),
        .in_b       (root_b),
        .adv        (adv),
        .strobe     (strobe),
        .span_valid (span_valid),
        .span_start (span_start),
        .span_end   (span_end),
        .last       (last)
    );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the shape row span rasterizer core.
`timescale 1ns / 1ps

module tb_top
    import srsr_pkg::*;
();

    localparam int LATENCY    = 8;
    localparam int STALL_MAX  = 4000;
    localparam int NUM_PHASES = 7;

    typedef struct {
        op_t               op;
        logic [CoordW-1:0] ax;
        logic [CoordW-1:0] ay;
        logic [CoordW-1:0] bx;
        logic [CoordW-1:0] by;
        logic [CoordW-1:0] sw;
        logic [CoordW-1:0] rw;
    } shape_req_t;

    typedef struct {
        logic              valid;
        logic [CoordW-1:0] lo;
        logic [CoordW-1:0] hi;
        logic              fin;
    } span_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cfg_we;
    logic              cfg_index;
    logic [DimW-1:0]   cfg_data;
    logic [1:0]        operation;
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic [CoordW-1:0] stroke;
    logic [CoordW-1:0] row;
    logic              strobe;
    logic              span_valid;
    logic [CoordW-1:0] span_start;
    logic [CoordW-1:0] span_end;
    logic              last;

    shape_req_t  pending_reqs[$];
    span_t       expected_spans[$];
    logic [DimW-1:0] canvas_w;
    logic [DimW-1:0] canvas_h;
    int          sender_idle_pct;
    int          error_count;
    int          stall_cycles;

    shape_row_span_rasterizer_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .operation(operation), .first_x(first_x), .first_y(first_y),
        .second_x(second_x), .second_y(second_y),
        .stroke(stroke), .row(row),
        .strobe(strobe), .span_valid(span_valid), .span_start(span_start),
        .span_end(span_end), .last(last)
    );

    always #5 clk = ~clk;

    // Integer square root, rounded down.
    function automatic int int_sqrt(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
        begin
            r = r + 1;
        end
        return r;
    endfunction

    // Clip one span to the canvas and keep it if non-empty.
    function automatic void add_span(input int lo, input int hi, input int w,
                                     inout int n, inout int los[2], inout int his[2]);
        if (lo < 0)
            lo = 0;
        if (hi > w - 1)
            hi = w - 1;
        if (lo <= hi && n < 2)
        begin
            los[n] = lo;
            his[n] = hi;
            n = n + 1;
        end
    endfunction

    // Compute the covered spans of one request and queue them.
    function automatic void predict_spans(input shape_req_t q);
        int w, h, sw, rw, ax, ay, bx, by;
        int x0, x1, y0, y1, le, rs;
        int rx, ry, r, dy, a, inner, in2, dy2, m, b, so, eo;
        int n;
        int los[2];
        int his[2];
        bit fill;
        span_t s;
        w  = (canvas_w > DIM_LIMIT) ? DIM_LIMIT : canvas_w;
        h  = (canvas_h > DIM_LIMIT) ? DIM_LIMIT : canvas_h;
        sw = (q.sw == 0) ? 1 : q.sw;
        rw = q.rw;
        ax = q.ax;
        ay = q.ay;
        bx = q.bx;
        by = q.by;
        n  = 0;
        if (rw < h && w > 0)
        begin
            if (q.op == OP_RECT_FILL || q.op == OP_RECT_LINE)
            begin
                x0 = (ax < bx) ? ax : bx;
                x1 = (ax < bx) ? bx : ax;
                y0 = (ay < by) ? ay : by;
                y1 = (ay < by) ? by : ay;
                fill = (q.op == OP_RECT_FILL) || sw >= x1 - x0 + 1 || sw >= y1 - y0 + 1;
                if (rw >= y0 && rw <= y1)
                begin
                    le = x0 + sw - 1;
                    rs = x1 - sw + 1;
                    if (fill || rw - y0 < sw || y1 - rw < sw || rs <= le + 1)
                        add_span(x0, x1, w, n, los, his);
                    else
                    begin
                        add_span(x0, le, w, n, los, his);
                        add_span(rs, x1, w, n, los, his);
                    end
                end
            end
            else
            begin
                rx = (bx > ax) ? bx - ax : ax - bx;
                ry = (by > ay) ? by - ay : ay - by;
                r  = (rx > ry) ? rx : ry;
                dy = (rw > ay) ? rw - ay : ay - rw;
                if (r == 0)
                begin
                    if (q.op == OP_CIRC_FILL)
                    begin
                        if (rw == ay)
                            add_span(ax, ax, w, n, los, his);
                    end
                    else
                    begin
                        so = -(sw / 2);
                        eo = so + sw - 1;
                        if (rw >= ay + so && rw <= ay + eo)
                            add_span(ax + so, ax + eo, w, n, los, his);
                    end
                end
                else if (dy <= r)
                begin
                    dy2 = dy * dy;
                    a = int_sqrt(r * r - dy2);
                    inner = r - sw + 1;
                    if (inner < 0)
                        inner = 0;
                    in2 = inner * inner;
                    if (q.op == OP_CIRC_FILL || in2 <= dy2)
                        add_span(ax - a, ax + a, w, n, los, his);
                    else
                    begin
                        m = in2 - dy2;
                        b = int_sqrt(m);
                        if (b * b < m)
                            b = b + 1;
                        if (b <= a)
                        begin
                            add_span(ax - a, ax - b, w, n, los, his);
                            add_span(ax + b, ax + a, w, n, los, his);
                        end
                    end
                end
            end
        end
        if (n == 0)
        begin
            s = '{1'b0, '0, '0, 1'b1};
            expected_spans.push_back(s);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                s = '{1'b1, los[i][CoordW-1:0], his[i][CoordW-1:0], i == n - 1};
                expected_spans.push_back(s);
            end
        end
    endfunction

    // Driver: present the next pending request, hold it until the transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            operation    <= '0;
            first_x      <= '0;
            first_y      <= '0;
            second_x     <= '0;
            second_y     <= '0;
            stroke       <= '0;
            row          <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
                predict_spans('{op_t'(operation), first_x, first_y, second_x, second_y,
                                stroke, row});
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                shape_req_t q;
                q = pending_reqs.pop_front();
                start        <= 1'b1;
                operation    <= q.op;
                first_x      <= q.ax;
                first_y      <= q.ay;
                second_x     <= q.bx;
                second_y     <= q.by;
                stroke       <= q.sw;
                row          <= q.rw;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each strobed result with the oldest expected span.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_spans.size() == 0)
            begin
                $error("unexpected result: valid %0d start %0d end %0d last %0d",
                       span_valid, span_start, span_end, last);
                error_count++;
            end
            else
            begin
                span_t e;
                e = expected_spans.pop_front();
                if (span_valid !== e.valid)
                begin
                    $error("span_valid: expected %0d, got %0d", e.valid, span_valid);
                    error_count++;
                end
                if (span_start !== e.lo)
                begin
                    $error("span_start: expected %0d, got %0d", e.lo, span_start);
                    error_count++;
                end
                if (span_end !== e.hi)
                begin
                    $error("span_end: expected %0d, got %0d", e.hi, span_end);
                    error_count++;
                end
                if (last !== e.fin)
                begin
                    $error("last: expected %0d, got %0d", e.fin, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic shape_req_t make_req(input int op, input int ax, input int ay,
                                            input int bx, input int by, input int sw,
                                            input int rw);
        shape_req_t q;
        q = '{op_t'(op[1:0]), ax[11:0], ay[11:0], bx[11:0], by[11:0], sw[11:0], rw[11:0]};
        return q;
    endfunction

    // Random request: mostly a shape near the asked row, sometimes pure noise.
    function automatic shape_req_t random_req();
        int ax, ay, ext, sw, rw, sel;
        if ($urandom_range(3) == 0)
            return make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        sel = $urandom_range(9);
        ext = (sel < 6) ? $urandom_range(40) : (sel < 9) ? $urandom_range(600) :
              $urandom_range(4095);
        ax  = (sel < 3) ? $urandom_range(60) : $urandom_range(4095);
        ay  = $urandom_range(4095);
        sw  = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(8);
        rw  = ay + $urandom_range(2 * ext + 2) - ext - 1;
        return make_req($urandom_range(3), ax, ay,
                        ax + $urandom_range(2 * ext) - ext,
                        ay + $urandom_range(2 * ext) - ext, sw, rw);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DimW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !start && expected_spans.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        int widths[NUM_PHASES];
        int heights[NUM_PHASES];
        widths  = '{4096, 1, 8191, 0, 4096, 100, 0};
        heights = '{4096, 1, 8191, 4096, 0, 4000, 0};
        widths[6]  = $urandom_range(1, 4096);
        heights[6] = $urandom_range(1, 4096);
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        error_count = 0;
        stall_cycles = 0;
        sender_idle_pct = 22;
        canvas_w = DIM_RESET;
        canvas_h = DIM_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset canvas size.
        pending_reqs.push_back(make_req(OP_RECT_FILL, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_RECT_FILL, 4095, 4095, 0, 0, 4095, 4095));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 10, 10, 50, 50, 3, 30));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 10, 10, 50, 50, 0, 10));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 10, 10, 50, 50, 41, 30));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 10, 10, 30, 50, 10, 30));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 4095, 0, 0, 4095, 1, 2000));
        pending_reqs.push_back(make_req(OP_RECT_LINE, 0, 0, 4095, 4095, 4095, 5));
        pending_reqs.push_back(make_req(OP_CIRC_FILL, 100, 100, 100, 100, 5, 100));
        pending_reqs.push_back(make_req(OP_CIRC_FILL, 100, 100, 100, 100, 5, 101));
        pending_reqs.push_back(make_req(OP_CIRC_FILL, 0, 0, 4095, 4095, 0, 0));
        pending_reqs.push_back(make_req(OP_CIRC_FILL, 2000, 2000, 2010, 2003, 0, 2010));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 0, 0, 0, 0, 4095, 0));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 4095, 4095, 4095, 4095, 4095, 3000));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 50, 50, 50, 50, 4, 48));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 50, 50, 50, 50, 0, 50));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 200, 200, 220, 200, 3, 200));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 200, 200, 220, 200, 3, 219));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 200, 200, 220, 200, 100, 205));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 5, 5, 4095, 0, 2, 4095));
        pending_reqs.push_back(make_req(OP_CIRC_LINE, 2048, 2048, 0, 0, 1, 2048));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sender_idle_pct = (p < 2) ? 22 : (p < 4) ? 87 : 0;
            if (p > 0)
            begin
                wait_drained();
                write_reg(CFG_WIDTH, widths[p]);
                write_reg(CFG_HEIGHT, heights[p]);
                canvas_w = widths[p][DimW-1:0];
                canvas_h = heights[p][DimW-1:0];
            end
            for (int i = 0; i < 115; i++)
                pending_reqs.push_back(random_req());
        end

        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
